// File: hdl/kap_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the keyed alpha paste block
package kap_pkg;

  // coordinate, color, register, weight and index widths
  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int REG_W    = 13;
  localparam int WEIGHT_W = 9;
  localparam int INDEX_W  = 3;

  // full source weight
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  // white key color per channel
  localparam logic [CHAN_W-1:0] KEY_LEVEL = 8'd255;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // paste modes
  typedef enum logic [1:0] {
    MODE_KEY_BLEND = 2'd0,
    MODE_KEY_COPY  = 2'd1,
    MODE_BLEND     = 2'd2,
    MODE_OFF       = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_DEST_WIDTH    = 3'd4,
    REG_DEST_HEIGHT   = 3'd5,
    REG_PASTE_MODE    = 3'd6,
    REG_BLEND_WEIGHT  = 3'd7
  } reg_index_t;

endpackage

// File: hdl/kap_blend.sv
`timescale 1ns / 1ps
// one color channel of the weighted source over destination blend
module kap_blend
  import kap_pkg::*;
(
  input  chan_t   src,
  input  chan_t   dst,
  input  weight_t weight,
  output chan_t   mixed
);

  logic [15:0] src_prod;
  logic [15:0] dst_prod;
  logic [15:0] sum;
  weight_t     inv_weight;

  // for w up to 256, src*w + dst*(256-w) never exceeds 255*256, so 16 bits hold it
  assign inv_weight = weight_t'(WEIGHT_ONE - weight);
  assign src_prod   = {8'b0, src} * {7'b0, weight};
  assign dst_prod   = {8'b0, dst} * {7'b0, inv_weight};
  assign sum        = src_prod + dst_prod;
  assign mixed      = sum[15:8];

endmodule

// File: hdl/keyed_alpha_paste.sv
`timescale 1ns / 1ps
// top level of the keyed alpha paste block
//
// Pastes a stream of source pixels onto a destination image at a signed
// offset. Each input word carries a source position, the source color and
// the destination color now at the target position. Each output word gives
// the target position, a write enable and the new color; with write enable
// low all other output fields are zero.
// Input and output channels use valid/stall: a word moves on an edge with
// valid high and stall low. The configuration channel (index, data) uses
// valid/ready and is always ready; write it only while the block is empty.
// An accepted word moves from the input register to the result register,
// with the clip, key and blend logic between them, and the output shows
// the result register. The two register stages take one word per cycle
// while the receiver does not stall.
// When the receiver stalls, the result register holds its word; an empty
// input register still takes one word, and once both stages are full
// in_stall follows out_stall in the same cycle.
// Reset empties both stages and sets offsets and sizes to 0, the mode to
// disabled and the blend weight to 256.
module keyed_alpha_paste
  import kap_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]    cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  src_col,
  input  logic [COORD_W-1:0]  src_row,
  input  chan_t               src_red,
  input  chan_t               src_green,
  input  chan_t               src_blue,
  input  chan_t               dst_red,
  input  chan_t               dst_green,
  input  chan_t               dst_blue,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                write_enable,
  output logic [COORD_W-1:0]  out_col,
  output logic [COORD_W-1:0]  out_row,
  output chan_t               out_red,
  output chan_t               out_green,
  output chan_t               out_blue
);

  // size cap as it fits in a size register
  localparam logic [REG_W-1:0] DIM_CAP =
    (MAX_DIM > (2 ** REG_W) - 1) ? {REG_W{1'b1}} : REG_W'(MAX_DIM);

  // configuration registers
  logic signed [REG_W-1:0] offset_x;
  logic signed [REG_W-1:0] offset_y;
  logic [REG_W-1:0]        source_width;
  logic [REG_W-1:0]        source_height;
  logic [REG_W-1:0]        dest_width;
  logic [REG_W-1:0]        dest_height;
  mode_t                   paste_mode;
  weight_t                 blend_weight;
  logic [REG_W-1:0]        dim_value;

  // input register stage
  logic                    s1_valid;
  logic [COORD_W-1:0]      s1_col;
  logic [COORD_W-1:0]      s1_row;
  chan_t                   s1_sr, s1_sg, s1_sb;
  chan_t                   s1_dr, s1_dg, s1_db;

  // handshake
  logic                    out_free;
  logic                    s1_free;
  logic                    in_take;

  // result logic
  logic signed [REG_W:0]   dest_col_full;
  logic signed [REG_W:0]   dest_row_full;
  logic                    col_in;
  logic                    row_in;
  logic                    white;
  logic                    over_weight;
  logic                    we_next;
  logic                    copy_next;
  chan_t                   mix_r, mix_g, mix_b;

  assign cfg_ready = 1'b1;

  // size writes above the cap count as the cap
  assign dim_value = (cfg_data > DIM_CAP) ? DIM_CAP : cfg_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      source_width  <= '0;
      source_height <= '0;
      dest_width    <= '0;
      dest_height   <= '0;
      paste_mode    <= MODE_OFF;
      blend_weight  <= WEIGHT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_OFFSET_X:      offset_x      <= cfg_data;
        REG_OFFSET_Y:      offset_y      <= cfg_data;
        REG_SOURCE_WIDTH:  source_width  <= dim_value;
        REG_SOURCE_HEIGHT: source_height <= dim_value;
        REG_DEST_WIDTH:    dest_width    <= dim_value;
        REG_DEST_HEIGHT:   dest_height   <= dim_value;
        REG_PASTE_MODE:    paste_mode    <= mode_t'(cfg_data[1:0]);
        REG_BLEND_WEIGHT:  blend_weight  <= cfg_data[WEIGHT_W-1:0];
      endcase
    end
  end

  // stage flow
  assign out_free = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || out_free;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col <= src_col;
      s1_row <= src_row;
      s1_sr  <= src_red;
      s1_sg  <= src_green;
      s1_sb  <= src_blue;
      s1_dr  <= dst_red;
      s1_dg  <= dst_green;
      s1_db  <= dst_blue;
    end
  end

  // target position, signed and wide enough for every offset
  assign dest_col_full = signed'({2'b00, s1_col}) + signed'({offset_x[REG_W-1], offset_x});
  assign dest_row_full = signed'({2'b00, s1_row}) + signed'({offset_y[REG_W-1], offset_y});

  // clip window: inside the source and inside the destination
  assign col_in = ({1'b0, s1_col} < source_width) && !dest_col_full[REG_W]
                  && (dest_col_full[REG_W-1:0] < dest_width);
  assign row_in = ({1'b0, s1_row} < source_height) && !dest_row_full[REG_W]
                  && (dest_row_full[REG_W-1:0] < dest_height);

  assign white       = (s1_sr == KEY_LEVEL) && (s1_sg == KEY_LEVEL) && (s1_sb == KEY_LEVEL);
  assign over_weight = blend_weight > WEIGHT_ONE;

  // mode decode
  always_comb begin
    we_next   = 1'b0;
    copy_next = 1'b0;
    unique case (paste_mode)
      MODE_KEY_BLEND: begin
        we_next   = !white;
        copy_next = over_weight;
      end
      MODE_KEY_COPY: begin
        we_next   = !white;
        copy_next = 1'b1;
      end
      MODE_BLEND: begin
        we_next   = !over_weight;
      end
      MODE_OFF: begin
        we_next   = 1'b0;
      end
    endcase
    we_next = we_next && col_in && row_in;
  end

  // per channel blend
  kap_blend u_blend_red (
    .src    (s1_sr),
    .dst    (s1_dr),
    .weight (blend_weight),
    .mixed  (mix_r)
  );

  kap_blend u_blend_green (
    .src    (s1_sg),
    .dst    (s1_dg),
    .weight (blend_weight),
    .mixed  (mix_g)
  );

  kap_blend u_blend_blue (
    .src    (s1_sb),
    .dst    (s1_db),
    .weight (blend_weight),
    .mixed  (mix_b)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      write_enable <= we_next;
      if (we_next) begin
        out_col   <= dest_col_full[COORD_W-1:0];
        out_row   <= dest_row_full[COORD_W-1:0];
        out_red   <= copy_next ? s1_sr : mix_r;
        out_green <= copy_next ? s1_sg : mix_g;
        out_blue  <= copy_next ? s1_sb : mix_b;
      end else begin
        out_col   <= '0;
        out_row   <= '0;
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
      end
    end
  end

  // a word with no write carries only zero fields
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |->
      (out_col == '0 && out_row == '0 && out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("no-write word has nonzero fields");

  // input stall only when both stages are full and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // an accepted word lands in the input register
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted word lost at input register");

  // a filled input register moves into the result register when it is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |=> out_valid)
    else $error("word lost between stages");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// testbench of the keyed alpha paste block with its own pixel predictor
module tb
  import kap_pkg::*;
();

  localparam int DIM_LIMIT   = 4096;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    chan_t              src_red;
    chan_t              src_green;
    chan_t              src_blue;
    chan_t              dst_red;
    chan_t              dst_green;
    chan_t              dst_blue;
  } pixel_t;

  typedef struct packed {
    logic               we;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    chan_t              red;
    chan_t              green;
    chan_t              blue;
  } paste_word_t;

  // raw register values as written, indexed by register index
  typedef logic [7:0][REG_W-1:0] reg_file_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = REG_OFFSET_X;
  logic [REG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] src_col   = '0;
  logic [COORD_W-1:0] src_row   = '0;
  chan_t              src_red   = '0;
  chan_t              src_green = '0;
  chan_t              src_blue  = '0;
  chan_t              dst_red   = '0;
  chan_t              dst_green = '0;
  chan_t              dst_blue  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               write_enable;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  chan_t              out_red;
  chan_t              out_green;
  chan_t              out_blue;

  reg_file_t   shadow_regs;
  paste_word_t paste_results_due[$];
  paste_word_t seen_word;
  paste_word_t want_word;
  int unsigned bad_words  = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_left = 0;
  bit          idle_on    = 1'b1;

  keyed_alpha_paste #(
    .MAX_DIM(DIM_LIMIT)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .src_col     (src_col),
    .src_row     (src_row),
    .src_red     (src_red),
    .src_green   (src_green),
    .src_blue    (src_blue),
    .dst_red     (dst_red),
    .dst_green   (dst_green),
    .dst_blue    (dst_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .write_enable(write_enable),
    .out_col     (out_col),
    .out_row     (out_row),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  // size registers saturate at the largest image dimension
  function automatic int clamp_dim(logic [REG_W-1:0] v);
    return (int'(v) > DIM_LIMIT) ? DIM_LIMIT : int'(v);
  endfunction

  // position inside both the source and the shifted destination
  function automatic bit in_window(int pos, int off, int src_size, int dst_size);
    int lo;
    int hi;
    lo = (off < 0) ? -off : 0;
    hi = dst_size - off;
    if (hi > src_size) hi = src_size;
    return (pos >= lo) && (pos < hi);
  endfunction

  function automatic chan_t blend_chan(chan_t s, chan_t d, int w);
    int mixed;
    mixed = (int'(s) * w + int'(d) * (int'(WEIGHT_ONE) - w)) >> 8;
    return chan_t'(mixed);
  endfunction

  function automatic paste_word_t predict_paste(pixel_t p, reg_file_t r);
    paste_word_t res;
    int          ox;
    int          oy;
    int          w;
    mode_t       m;
    bit          white;
    bit          copy;
    bit          wr;
    res   = '0;
    ox    = $signed(r[REG_OFFSET_X]);
    oy    = $signed(r[REG_OFFSET_Y]);
    w     = int'(r[REG_BLEND_WEIGHT][WEIGHT_W-1:0]);
    m     = mode_t'(r[REG_PASTE_MODE][1:0]);
    white = (p.src_red == KEY_LEVEL) && (p.src_green == KEY_LEVEL) &&
            (p.src_blue == KEY_LEVEL);
    copy  = 1'b0;
    wr    = 1'b0;
    if (!in_window(int'(p.col), ox, clamp_dim(r[REG_SOURCE_WIDTH]),
                   clamp_dim(r[REG_DEST_WIDTH])) ||
        !in_window(int'(p.row), oy, clamp_dim(r[REG_SOURCE_HEIGHT]),
                   clamp_dim(r[REG_DEST_HEIGHT])))
      return res;
    case (m)
      MODE_KEY_BLEND: begin
        wr   = !white;
        copy = (w > int'(WEIGHT_ONE));
      end
      MODE_KEY_COPY: begin
        wr   = !white;
        copy = 1'b1;
      end
      MODE_BLEND: begin
        wr = (w <= int'(WEIGHT_ONE));
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    if (!wr) return res;
    res.we  = 1'b1;
    res.col = COORD_W'(int'(p.col) + ox);
    res.row = COORD_W'(int'(p.row) + oy);
    if (copy) begin
      res.red   = p.src_red;
      res.green = p.src_green;
      res.blue  = p.src_blue;
    end else begin
      res.red   = blend_chan(p.src_red, p.dst_red, w);
      res.green = blend_chan(p.src_green, p.dst_green, w);
      res.blue  = blend_chan(p.src_blue, p.dst_blue, w);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  function automatic pixel_t mk_pixel(int c, int r, int sr, int sg, int sb,
                                      int dr, int dg, int db);
    pixel_t p;
    p.col       = COORD_W'(c);
    p.row       = COORD_W'(r);
    p.src_red   = chan_t'(sr);
    p.src_green = chan_t'(sg);
    p.src_blue  = chan_t'(sb);
    p.dst_red   = chan_t'(dr);
    p.dst_green = chan_t'(dg);
    p.dst_blue  = chan_t'(db);
    return p;
  endfunction

  function automatic reg_file_t mk_regs(int ox, int oy, int sw, int sh, int dw,
                                        int dh, mode_t m, int w);
    reg_file_t r;
    r[REG_OFFSET_X]      = REG_W'(ox);
    r[REG_OFFSET_Y]      = REG_W'(oy);
    r[REG_SOURCE_WIDTH]  = REG_W'(sw);
    r[REG_SOURCE_HEIGHT] = REG_W'(sh);
    r[REG_DEST_WIDTH]    = REG_W'(dw);
    r[REG_DEST_HEIGHT]   = REG_W'(dh);
    r[REG_PASTE_MODE]    = REG_W'(m);
    r[REG_BLEND_WEIGHT]  = REG_W'(w);
    return r;
  endfunction

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return KEY_LEVEL;
      default: return chan_t'($urandom());
    endcase
  endfunction

  // mostly small positions near the usual window, some anywhere
  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.col       = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom())
                                              : COORD_W'($urandom_range(0, 63));
    p.row       = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom())
                                              : COORD_W'($urandom_range(0, 63));
    p.src_red   = rand_chan();
    p.src_green = rand_chan();
    p.src_blue  = rand_chan();
    p.dst_red   = rand_chan();
    p.dst_green = rand_chan();
    p.dst_blue  = rand_chan();
    if ($urandom_range(0, 5) == 0) begin
      p.src_red   = KEY_LEVEL;
      p.src_green = KEY_LEVEL;
      p.src_blue  = KEY_LEVEL;
    end
    return p;
  endfunction

  function automatic logic [REG_W-1:0] rand_offset();
    case ($urandom_range(0, 5))
      0:       return 13'h1000;
      1:       return 13'h0FFF;
      2:       return REG_W'($urandom());
      default: return REG_W'($urandom_range(0, 32) - 16);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_dim();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return REG_W'(DIM_LIMIT);
      2:       return 13'h1FFF;
      3:       return REG_W'($urandom());
      default: return REG_W'($urandom_range(1, 40));
    endcase
  endfunction

  // unused upper bits of the mode and weight registers carry junk
  function automatic reg_file_t rand_regs();
    reg_file_t r;
    int        w;
    case ($urandom_range(0, 5))
      0:       w = 0;
      1:       w = int'(WEIGHT_ONE);
      2:       w = $urandom_range(257, 511);
      3:       w = 511;
      default: w = $urandom_range(0, 256);
    endcase
    r[REG_OFFSET_X]      = rand_offset();
    r[REG_OFFSET_Y]      = rand_offset();
    r[REG_SOURCE_WIDTH]  = rand_dim();
    r[REG_SOURCE_HEIGHT] = rand_dim();
    r[REG_DEST_WIDTH]    = rand_dim();
    r[REG_DEST_HEIGHT]   = rand_dim();
    r[REG_PASTE_MODE]    = REG_W'($urandom());
    r[REG_BLEND_WEIGHT]  = {4'($urandom_range(0, 15)), WEIGHT_W'(w)};
    return r;
  endfunction

  // ---------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------

  // send one pixel word, with an occasional gap ahead of it
  task automatic push_pixel(pixel_t p);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    src_col   <= p.col;
    src_row   <= p.row;
    src_red   <= p.src_red;
    src_green <= p.src_green;
    src_blue  <= p.src_blue;
    dst_red   <= p.dst_red;
    dst_green <= p.dst_green;
    dst_blue  <= p.dst_blue;
    do @(posedge clk); while (in_stall);
    paste_results_due.push_back(predict_paste(p, shadow_regs));
  endtask

  // drop valid and let every pending word come out
  task automatic wait_paste_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (paste_results_due.size() != 0);
  endtask

  // write all registers in index order; block must be empty
  task automatic load_config(reg_file_t vals);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid   <= 1'b0;
    shadow_regs  = vals;
  endtask

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // reset leaves the block disabled with empty images
  task automatic test_reset_state();
    push_pixel(mk_pixel(0, 0, 1, 2, 3, 4, 5, 6));
    push_pixel(mk_pixel(4095, 4095, 255, 0, 255, 0, 255, 0));
  endtask

  // clip window edges, extreme offsets and oversized sizes
  task automatic test_clip_window();
    wait_paste_done();
    load_config(mk_regs(5, -3, 16, 16, 20, 20, MODE_KEY_BLEND, 128));
    push_pixel(mk_pixel(0, 3, 0, 0, 0, 255, 255, 255));
    push_pixel(mk_pixel(14, 15, 255, 255, 254, 0, 0, 0));
    push_pixel(mk_pixel(15, 3, 10, 20, 30, 40, 50, 60));
    push_pixel(mk_pixel(0, 2, 10, 20, 30, 40, 50, 60));
    push_pixel(mk_pixel(14, 16, 10, 20, 30, 40, 50, 60));
    push_pixel(mk_pixel(4095, 4095, 200, 100, 50, 25, 12, 6));
    wait_paste_done();
    load_config(mk_regs(-256, 16, 8191, 20, 4096, 8191, MODE_BLEND, 0));
    push_pixel(mk_pixel(4095, 19, 255, 255, 255, 17, 34, 51));
    push_pixel(mk_pixel(255, 0, 1, 1, 1, 2, 2, 2));
    push_pixel(mk_pixel(256, 0, 90, 80, 70, 255, 128, 0));
    wait_paste_done();
    load_config(mk_regs(4095, -4096, 8191, 8191, 8191, 8191, MODE_KEY_COPY, 0));
    push_pixel(mk_pixel(0, 4095, 9, 8, 7, 6, 5, 4));
  endtask

  // every mode, the white key and weights at and beyond full
  task automatic test_modes();
    wait_paste_done();
    load_config(mk_regs(0, 0, 8, 8, 8, 8, MODE_KEY_BLEND, 300));
    push_pixel(mk_pixel(1, 1, 255, 255, 255, 3, 3, 3));
    push_pixel(mk_pixel(2, 2, 10, 20, 30, 200, 200, 200));
    wait_paste_done();
    load_config(mk_regs(0, 0, 8, 8, 8, 8, MODE_KEY_COPY, 0));
    push_pixel(mk_pixel(3, 3, 255, 255, 255, 1, 2, 3));
    push_pixel(mk_pixel(7, 7, 254, 255, 255, 1, 2, 3));
    wait_paste_done();
    load_config(mk_regs(0, 0, 8, 8, 8, 8, MODE_BLEND, 256));
    push_pixel(mk_pixel(4, 4, 255, 255, 255, 0, 0, 0));
    push_pixel(mk_pixel(5, 6, 12, 34, 56, 78, 90, 123));
    wait_paste_done();
    load_config(mk_regs(0, 0, 8, 8, 8, 8, MODE_BLEND, 511));
    push_pixel(mk_pixel(5, 6, 12, 34, 56, 78, 90, 123));
    wait_paste_done();
    load_config(mk_regs(0, 0, 8, 8, 8, 8, MODE_OFF, 128));
    push_pixel(mk_pixel(5, 6, 12, 34, 56, 78, 90, 123));
  endtask

  // random settings, random pixels
  task automatic test_random_paste();
    for (int ph = 0; ph < 12; ph++) begin
      wait_paste_done();
      load_config(rand_regs());
      repeat (120) push_pixel(rand_pixel());
    end
  endtask

  // sender holds off until the block has drained
  task automatic test_drain_pause();
    wait_paste_done();
    load_config(rand_regs());
    repeat (40) push_pixel(rand_pixel());
    wait_paste_done();
    repeat (40) push_pixel(rand_pixel());
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int ph = 0; ph < 2; ph++) begin
      wait_paste_done();
      load_config(rand_regs());
      repeat (80) push_pixel(rand_pixel());
    end
  endtask

  // ---------------------------------------------------------------
  // receiver, checker, watchdog
  // ---------------------------------------------------------------

  // output stall in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each output word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word = {write_enable, out_col, out_row, out_red, out_green, out_blue};
      if (paste_results_due.size() == 0) begin
        if (bad_words < 10)
          $display("unexpected word: we=%0b col=%0d row=%0d rgb=%h %h %h",
                   seen_word.we, seen_word.col, seen_word.row,
                   seen_word.red, seen_word.green, seen_word.blue);
        bad_words++;
      end else begin
        want_word = paste_results_due.pop_front();
        if (seen_word !== want_word) begin
          if (bad_words < 10)
            $display({"mismatch: want we=%0b col=%0d row=%0d rgb=%h %h %h,",
                      " got we=%0b col=%0d row=%0d rgb=%h %h %h"},
                     want_word.we, want_word.col, want_word.row,
                     want_word.red, want_word.green, want_word.blue,
                     seen_word.we, seen_word.col, seen_word.row,
                     seen_word.red, seen_word.green, seen_word.blue);
          bad_words++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("keyed_alpha_paste test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------
  initial begin
    shadow_regs = mk_regs(0, 0, 0, 0, 0, 0, MODE_OFF, int'(WEIGHT_ONE));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_clip_window();
    test_modes();
    test_random_paste();
    test_drain_pause();
    test_back_to_back();
    wait_paste_done();
    repeat (8) @(posedge clk);
    if (bad_words == 0) begin
      $display("keyed_alpha_paste test passed");
    end else begin
      $display("keyed_alpha_paste test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/kap_pkg.sv
hdl/kap_blend.sv
hdl/keyed_alpha_paste.sv
verif/tb.sv
